@@ design/lpc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpc_pkg: shared types and constants of the page-cache tag store
// Opcodes, result codes, line states and the command that the control logic
// hands to the entry array.
// ----------------------------------------------------------------------------
package lpc_pkg;

    localparam int ENTRIES_DEF    = 16;
    localparam int PAGE_BYTES_DEF = 4096;

    localparam int OPCODE_W = 3;
    localparam int INODE_W  = 32;
    localparam int OFFSET_W = 64;
    localparam int BYTES_W  = 13;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 4;
    localparam int FLUSH_W  = 5;
    localparam int TOTAL_W  = 32;

    typedef enum logic [OPCODE_W-1:0] {
        OP_LOOKUP     = 3'd0,
        OP_INSERT     = 3'd1,
        OP_INVALIDATE = 3'd2,
        OP_FLUSH      = 3'd3,
        OP_CLEAR      = 3'd4
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        RES_DONE     = 2'd0,
        RES_MISS     = 2'd1,
        RES_REJECT   = 2'd2,
        RES_NOTFOUND = 2'd3
    } result_t;

    typedef enum logic [1:0] {
        LS_INVALID = 2'd0,
        LS_VALID   = 2'd1,
        LS_DIRTY   = 2'd2
    } line_st_t;

    // Update request for the entry array; the entry index travels beside it.
    typedef struct packed {
        logic     fill;
        logic     set_status;
        line_st_t new_status;
        logic     flush;
        logic     clear;
    } lpc_arr_cmd_t;

endpackage

@@ design/lpc_entry_array.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpc_entry_array: tags and line states of all entries
// Compares every valid entry against the tag in parallel, finds the first
// free entry, counts dirty lines and applies fill, status, flush and clear.
// ----------------------------------------------------------------------------
module lpc_entry_array #(
    parameter int ENTRIES = lpc_pkg::ENTRIES_DEF,
    parameter int IDX_W   = $clog2(ENTRIES),
    parameter int CNT_W   = $clog2(ENTRIES + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [lpc_pkg::INODE_W-1:0] inode,
    input  logic [lpc_pkg::OFFSET_W-1:0] page_offset,
    input  lpc_pkg::lpc_arr_cmd_t       cmd,
    input  logic [IDX_W-1:0]            wr_idx,
    input  logic [IDX_W-1:0]            victim_idx,
    output logic [ENTRIES-1:0]          hit_vec,
    output logic                        hit,
    output logic [IDX_W-1:0]            hit_idx,
    output logic                        free_any,
    output logic [IDX_W-1:0]            free_idx,
    output logic                        victim_dirty,
    output logic [CNT_W-1:0]            dirty_cnt
);
    import lpc_pkg::*;

    logic [INODE_W-1:0]  tag_ino_reg [ENTRIES];
    logic [OFFSET_W-1:0] tag_off_reg [ENTRIES];
    line_st_t            st_reg      [ENTRIES];
    line_st_t            st_next     [ENTRIES];
    logic [ENTRIES-1:0]  free_vec;

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            hit_vec[i]  = (st_reg[i] != LS_INVALID) && (tag_ino_reg[i] == inode) &&
                          (tag_off_reg[i] == page_offset);
            free_vec[i] = (st_reg[i] == LS_INVALID);
        end
    end

    // Lowest-numbered entry wins in both searches.
    always_comb
    begin
        hit_idx  = '0;
        free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (hit_vec[i])
            begin
                hit_idx = IDX_W'(i);
            end
            if (free_vec[i])
            begin
                free_idx = IDX_W'(i);
            end
        end
    end

    assign hit          = |hit_vec;
    assign free_any     = |free_vec;
    assign victim_dirty = (st_reg[victim_idx] == LS_DIRTY);

    always_comb
    begin
        dirty_cnt = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            dirty_cnt = dirty_cnt + CNT_W'(st_reg[i] == LS_DIRTY);
        end
    end

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            st_next[i] = st_reg[i];
            if (cmd.clear)
            begin
                st_next[i] = LS_INVALID;
            end
            else if (cmd.flush && (st_reg[i] == LS_DIRTY))
            begin
                st_next[i] = LS_VALID;
            end
            else if (cmd.set_status && (wr_idx == IDX_W'(i)))
            begin
                st_next[i] = cmd.new_status;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                st_reg[i] <= LS_INVALID;
            end
        end
        else
        begin
            st_reg <= st_next;
        end
    end

    // Tags are only compared behind a valid state, so they need no reset.
    always_ff @(posedge clk)
    begin
        if (cmd.fill)
        begin
            tag_ino_reg[wr_idx] <= inode;
            tag_off_reg[wr_idx] <= page_offset;
        end
    end

endmodule

@@ design/lpc_lru_rank.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpc_lru_rank: true LRU recency ranks
// Rank 0 is the most recent entry. The ranks always form a permutation, so
// the least recent entry is the single one that holds the top rank.
// ----------------------------------------------------------------------------
module lpc_lru_rank #(
    parameter int ENTRIES = lpc_pkg::ENTRIES_DEF,
    parameter int IDX_W   = $clog2(ENTRIES)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               touch,
    input  logic [IDX_W-1:0]   touch_idx,
    output logic [ENTRIES-1:0] lru_vec,
    output logic [IDX_W-1:0]   lru_idx
);
    import lpc_pkg::*;

    localparam logic [IDX_W-1:0] TOP_RANK = IDX_W'(ENTRIES - 1);

    logic [IDX_W-1:0] rank_reg  [ENTRIES];
    logic [IDX_W-1:0] rank_next [ENTRIES];
    logic [IDX_W-1:0] touch_rank;

    assign touch_rank = rank_reg[touch_idx];

    always_comb
    begin
        lru_idx = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            lru_vec[i] = (rank_reg[i] == TOP_RANK);
            if (lru_vec[i])
            begin
                lru_idx = IDX_W'(i);
            end
        end
    end

    // Everything more recent than the touched entry ages by one.
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            rank_next[i] = rank_reg[i];
            if (touch)
            begin
                if (touch_idx == IDX_W'(i))
                begin
                    rank_next[i] = '0;
                end
                else if (rank_reg[i] < touch_rank)
                begin
                    rank_next[i] = rank_reg[i] + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_reg[i] <= IDX_W'(i);
            end
        end
        else
        begin
            rank_reg <= rank_next;
        end
    end

endmodule

@@ design/lru_page_cache_tag_store_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_page_cache_tag_store_top: fully associative page-cache tag store
// Tags keyed by inode and page offset, true LRU replacement, dirty tracking,
// and running hit, miss, writeback and eviction counters.
// ----------------------------------------------------------------------------
//  Channel   Handshake          Payload
//  command   start / busy       opcode, inode, page_offset, page_bytes,
//                               mark_dirty, count_miss
//  result    done (one cycle)   status, slot, writeback_needed, flushed_count,
//                               hit_total, miss_total, writeback_total,
//                               evict_total
//
//  One item per cycle: busy stays low, and an item is accepted whenever
//  start is high. The item is registered, then the tag compare, free/LRU
//  pick and rank update work combinationally on it, and the result register and done capture the outcome.
//  Back-to-back items see each other's updates since state is written at the
//  same edge as the result. Reset clears all lines to invalid, sets the ranks
//  to the entry index and zeroes the counters; no clearing pass is needed.
// ----------------------------------------------------------------------------
module lru_page_cache_tag_store_top #(
    parameter int ENTRIES    = lpc_pkg::ENTRIES_DEF,
    parameter int PAGE_BYTES = lpc_pkg::PAGE_BYTES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [lpc_pkg::OPCODE_W-1:0] opcode,
    input  logic [lpc_pkg::INODE_W-1:0]  inode,
    input  logic [lpc_pkg::OFFSET_W-1:0] page_offset,
    input  logic [lpc_pkg::BYTES_W-1:0]  page_bytes,
    input  logic                         mark_dirty,
    input  logic                         count_miss,
    output logic                         done,
    output logic [lpc_pkg::STATUS_W-1:0] status,
    output logic [lpc_pkg::SLOT_W-1:0]   slot,
    output logic                         writeback_needed,
    output logic [lpc_pkg::FLUSH_W-1:0]  flushed_count,
    output logic [lpc_pkg::TOTAL_W-1:0]  hit_total,
    output logic [lpc_pkg::TOTAL_W-1:0]  miss_total,
    output logic [lpc_pkg::TOTAL_W-1:0]  writeback_total,
    output logic [lpc_pkg::TOTAL_W-1:0]  evict_total
);
    import lpc_pkg::*;

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int SEXT_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
    localparam int FEXT_W = (CNT_W > FLUSH_W) ? CNT_W : FLUSH_W;
    localparam logic [BYTES_W-1:0] PAGE_LIMIT = BYTES_W'(PAGE_BYTES);

    // Input register.
    logic                in_vld_reg;
    opcode_t             op_reg;
    logic [INODE_W-1:0]  ino_reg;
    logic [OFFSET_W-1:0] off_reg;
    logic [BYTES_W-1:0]  bytes_reg;
    logic                dirty_reg;
    logic                cmiss_reg;

    // Result register.
    logic                done_reg;
    result_t             status_reg;
    result_t             status_next;
    logic [SLOT_W-1:0]   slot_reg;
    logic [SLOT_W-1:0]   slot_next;
    logic                wb_reg;
    logic                wb_next;
    logic [FLUSH_W-1:0]  flushed_reg;
    logic [FLUSH_W-1:0]  flushed_next;

    logic [TOTAL_W-1:0]  hit_cnt_reg;
    logic [TOTAL_W-1:0]  hit_cnt_next;
    logic [TOTAL_W-1:0]  miss_cnt_reg;
    logic [TOTAL_W-1:0]  miss_cnt_next;
    logic [TOTAL_W-1:0]  wb_cnt_reg;
    logic [TOTAL_W-1:0]  wb_cnt_next;
    logic [TOTAL_W-1:0]  evict_cnt_reg;
    logic [TOTAL_W-1:0]  evict_cnt_next;

    lpc_arr_cmd_t        arr_cmd;
    logic [IDX_W-1:0]    tgt_idx;
    logic                touch;
    logic [ENTRIES-1:0]  hit_vec;
    logic                hit;
    logic [IDX_W-1:0]    hit_idx;
    logic                free_any;
    logic [IDX_W-1:0]    free_idx;
    logic                victim_dirty;
    logic [CNT_W-1:0]    dirty_cnt;
    logic [ENTRIES-1:0]  lru_vec;
    logic [IDX_W-1:0]    lru_idx;
    logic [SEXT_W-1:0]   slot_ext;
    logic [FEXT_W-1:0]   flushed_ext;

    assign busy = 1'b0;

    lpc_entry_array #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W),
        .CNT_W   (CNT_W)
    ) u_array (
        .clk          (clk),
        .rst_n        (rst_n),
        .inode        (ino_reg),
        .page_offset  (off_reg),
        .cmd          (arr_cmd),
        .wr_idx       (tgt_idx),
        .victim_idx   (lru_idx),
        .hit_vec      (hit_vec),
        .hit          (hit),
        .hit_idx      (hit_idx),
        .free_any     (free_any),
        .free_idx     (free_idx),
        .victim_dirty (victim_dirty),
        .dirty_cnt    (dirty_cnt)
    );

    lpc_lru_rank #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W)
    ) u_lru (
        .clk       (clk),
        .rst_n     (rst_n),
        .touch     (touch),
        .touch_idx (tgt_idx),
        .lru_vec   (lru_vec),
        .lru_idx   (lru_idx)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            op_reg    <= opcode_t'(opcode);
            ino_reg   <= inode;
            off_reg   <= page_offset;
            bytes_reg <= page_bytes;
            dirty_reg <= mark_dirty;
            cmiss_reg <= count_miss;
        end
    end

    assign flushed_ext = FEXT_W'(dirty_cnt);

    always_comb
    begin
        status_next    = RES_DONE;
        tgt_idx        = '0;
        wb_next        = 1'b0;
        flushed_next   = '0;
        touch          = 1'b0;
        arr_cmd        = '0;
        arr_cmd.new_status = LS_INVALID;
        hit_cnt_next   = hit_cnt_reg;
        miss_cnt_next  = miss_cnt_reg;
        wb_cnt_next    = wb_cnt_reg;
        evict_cnt_next = evict_cnt_reg;

        if (in_vld_reg)
        begin
            case (op_reg)
                OP_LOOKUP:
                begin
                    if (ino_reg == '0)
                    begin
                        status_next = RES_REJECT;
                    end
                    else if (hit)
                    begin
                        tgt_idx      = hit_idx;
                        touch        = 1'b1;
                        hit_cnt_next = hit_cnt_reg + 1'b1;
                    end
                    else
                    begin
                        status_next = RES_MISS;
                        if (cmiss_reg)
                        begin
                            miss_cnt_next = miss_cnt_reg + 1'b1;
                        end
                    end
                end
                OP_INSERT:
                begin
                    if ((ino_reg == '0) || (bytes_reg > PAGE_LIMIT))
                    begin
                        status_next = RES_REJECT;
                    end
                    else
                    begin
                        if (hit)
                        begin
                            tgt_idx = hit_idx;
                        end
                        else if (free_any)
                        begin
                            tgt_idx      = free_idx;
                            arr_cmd.fill = 1'b1;
                        end
                        else
                        begin
                            // All entries in use: replace the least recent one.
                            tgt_idx        = lru_idx;
                            arr_cmd.fill   = 1'b1;
                            evict_cnt_next = evict_cnt_reg + 1'b1;
                            if (victim_dirty)
                            begin
                                wb_next     = 1'b1;
                                wb_cnt_next = wb_cnt_reg + 1'b1;
                            end
                        end
                        arr_cmd.set_status = 1'b1;
                        arr_cmd.new_status = dirty_reg ? LS_DIRTY : LS_VALID;
                        touch              = 1'b1;
                    end
                end
                OP_INVALIDATE:
                begin
                    if (ino_reg == '0)
                    begin
                        status_next = RES_REJECT;
                    end
                    else if (hit)
                    begin
                        // The slot stays 0 here; only the index for the write moves.
                        tgt_idx            = hit_idx;
                        arr_cmd.set_status = 1'b1;
                        arr_cmd.new_status = LS_INVALID;
                    end
                    else
                    begin
                        status_next = RES_NOTFOUND;
                    end
                end
                OP_FLUSH:
                begin
                    arr_cmd.flush = 1'b1;
                    flushed_next  = flushed_ext[FLUSH_W-1:0];
                    wb_cnt_next   = wb_cnt_reg + TOTAL_W'(dirty_cnt);
                end
                OP_CLEAR:
                begin
                    arr_cmd.clear = 1'b1;
                end
                default:
                begin
                    status_next = RES_REJECT;
                end
            endcase
        end
    end

    // An invalidate writes through tgt_idx but reports slot 0.
    assign slot_ext  = (touch) ? SEXT_W'(tgt_idx) : '0;
    assign slot_next = slot_ext[SLOT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg      <= 1'b0;
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            wb_cnt_reg    <= '0;
            evict_cnt_reg <= '0;
        end
        else
        begin
            done_reg      <= in_vld_reg;
            hit_cnt_reg   <= hit_cnt_next;
            miss_cnt_reg  <= miss_cnt_next;
            wb_cnt_reg    <= wb_cnt_next;
            evict_cnt_reg <= evict_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_vld_reg)
        begin
            status_reg  <= status_next;
            slot_reg    <= slot_next;
            wb_reg      <= wb_next;
            flushed_reg <= flushed_next;
        end
    end

    // The counters change only together with a result, so they are shown live.
    assign done             = done_reg;
    assign status           = status_reg;
    assign slot             = slot_reg;
    assign writeback_needed = wb_reg;
    assign flushed_count    = flushed_reg;
    assign hit_total        = hit_cnt_reg;
    assign miss_total       = miss_cnt_reg;
    assign writeback_total  = wb_cnt_reg;
    assign evict_total      = evict_cnt_reg;

    a_lru_unique: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(lru_vec))
        else $error("LRU ranks no longer hold exactly one least recent entry");

    a_tag_unique: assert property (@(posedge clk) disable iff (!rst_n)
        in_vld_reg |-> $onehot0(hit_vec))
        else $error("more than one entry matches the same tag");

    a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (status_reg == RES_REJECT)) |-> ((slot_reg == '0) && !wb_reg))
        else $error("rejected item reports a slot or writeback");

    a_hit_count: assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && (hit_cnt_next != hit_cnt_reg)) |=>
            (done_reg && (status_reg == RES_DONE)))
        else $error("hit counter moved without a hit result");

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of the page-cache tag store
// Sends lookup, insert, invalidate, flush and clear items over start/busy,
// keeps a mirror of the tags, line states, LRU ranks and counters in a small
// scoreboard class, and checks every result in order, field by field.
// ----------------------------------------------------------------------------
module tb;
    import lpc_pkg::*;

    localparam int NUM_LINES       = ENTRIES_DEF;
    localparam int PAGE_LIMIT      = PAGE_BYTES_DEF;
    localparam int BYTES_MAX       = (1 << BYTES_W) - 1;
    localparam int OPCODE_MAX      = (1 << OPCODE_W) - 1;
    localparam int INODE_POOL      = 6;
    localparam int OFFSET_POOL     = 5;
    localparam int ITEMS_PER_PHASE = 500;
    localparam int TAIL_CYCLES     = 8;
    localparam int WATCHDOG_LIMIT  = 2000;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [INODE_W-1:0]  inode;
        logic [OFFSET_W-1:0] page_offset;
        logic [BYTES_W-1:0]  page_bytes;
        logic                mark_dirty;
        logic                count_miss;
    } command_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic                writeback_needed;
        logic [FLUSH_W-1:0]  flushed_count;
        logic [TOTAL_W-1:0]  hit_total;
        logic [TOTAL_W-1:0]  miss_total;
        logic [TOTAL_W-1:0]  writeback_total;
        logic [TOTAL_W-1:0]  evict_total;
    } outcome_t;

    class tag_store_mirror;
        logic [INODE_W-1:0]  line_inode  [NUM_LINES];
        logic [OFFSET_W-1:0] line_offset [NUM_LINES];
        line_st_t            line_state  [NUM_LINES];
        int unsigned         line_rank   [NUM_LINES];
        logic [TOTAL_W-1:0]  hits;
        logic [TOTAL_W-1:0]  misses;
        logic [TOTAL_W-1:0]  writebacks;
        logic [TOTAL_W-1:0]  evictions;
        outcome_t            expected_results[$];
        int unsigned         mismatches;

        function new();
            for (int i = 0; i < NUM_LINES; i++)
            begin
                line_inode[i]  = '0;
                line_offset[i] = '0;
                line_state[i]  = LS_INVALID;
                line_rank[i]   = i;
            end
            hits       = '0;
            misses     = '0;
            writebacks = '0;
            evictions  = '0;
            mismatches = 0;
        endfunction

        function int find_line(logic [INODE_W-1:0] ino, logic [OFFSET_W-1:0] off);
            for (int i = 0; i < NUM_LINES; i++)
            begin
                if (line_state[i] != LS_INVALID && line_inode[i] == ino &&
                    line_offset[i] == off)
                    return i;
            end
            return -1;
        endfunction

        // Lines more recent than the promoted one age by one rank.
        function void promote(int e);
            int unsigned r;
            r = line_rank[e];
            for (int i = 0; i < NUM_LINES; i++)
            begin
                if (line_rank[i] < r)
                    line_rank[i] = line_rank[i] + 1;
            end
            line_rank[e] = 0;
        endfunction

        // A free line always wins over the least recently used one.
        function int pick_victim();
            int oldest;
            oldest = 0;
            for (int i = 0; i < NUM_LINES; i++)
            begin
                if (line_state[i] == LS_INVALID)
                    return i;
            end
            for (int i = 1; i < NUM_LINES; i++)
            begin
                if (line_rank[i] > line_rank[oldest])
                    oldest = i;
            end
            return oldest;
        endfunction

        function outcome_t predict_outcome(command_t c);
            outcome_t r;
            int       e;
            r = '0;
            r.status = RES_DONE;
            case (c.opcode)
                OP_LOOKUP:
                begin
                    if (c.inode == '0)
                        r.status = RES_REJECT;
                    else
                    begin
                        e = find_line(c.inode, c.page_offset);
                        if (e >= 0)
                        begin
                            promote(e);
                            hits = hits + 1;
                            r.slot = e[SLOT_W-1:0];
                        end
                        else
                        begin
                            r.status = RES_MISS;
                            if (c.count_miss)
                                misses = misses + 1;
                        end
                    end
                end
                OP_INSERT:
                begin
                    if (c.inode == '0 || c.page_bytes > PAGE_LIMIT)
                        r.status = RES_REJECT;
                    else
                    begin
                        e = find_line(c.inode, c.page_offset);
                        if (e < 0)
                        begin
                            e = pick_victim();
                            if (line_state[e] != LS_INVALID)
                            begin
                                evictions = evictions + 1;
                                if (line_state[e] == LS_DIRTY)
                                begin
                                    r.writeback_needed = 1'b1;
                                    writebacks = writebacks + 1;
                                end
                            end
                            line_inode[e]  = c.inode;
                            line_offset[e] = c.page_offset;
                        end
                        line_state[e] = c.mark_dirty ? LS_DIRTY : LS_VALID;
                        promote(e);
                        r.slot = e[SLOT_W-1:0];
                    end
                end
                OP_INVALIDATE:
                begin
                    if (c.inode == '0)
                        r.status = RES_REJECT;
                    else
                    begin
                        e = find_line(c.inode, c.page_offset);
                        if (e >= 0)
                            line_state[e] = LS_INVALID;
                        else
                            r.status = RES_NOTFOUND;
                    end
                end
                OP_FLUSH:
                begin
                    for (int i = 0; i < NUM_LINES; i++)
                    begin
                        if (line_state[i] == LS_DIRTY)
                        begin
                            line_state[i] = LS_VALID;
                            writebacks = writebacks + 1;
                            r.flushed_count = r.flushed_count + 1;
                        end
                    end
                end
                OP_CLEAR:
                begin
                    for (int i = 0; i < NUM_LINES; i++)
                        line_state[i] = LS_INVALID;
                end
                default:
                    r.status = RES_REJECT;
            endcase
            r.hit_total       = hits;
            r.miss_total      = misses;
            r.writeback_total = writebacks;
            r.evict_total     = evictions;
            return r;
        endfunction

        function void note_command(command_t c);
            expected_results.push_back(predict_outcome(c));
        endfunction

        function void compare_field(string name, logic [63:0] exp_val,
                                    logic [63:0] act_val);
            if (exp_val !== act_val)
            begin
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, exp_val, act_val);
                mismatches++;
            end
        endfunction

        function void check_result(outcome_t act);
            outcome_t exp;
            if (expected_results.size() == 0)
            begin
                $display("%0t: result with no item pending, expected none, actual status %0d",
                         $time, act.status);
                mismatches++;
            end
            else
            begin
                exp = expected_results.pop_front();
                compare_field("status", exp.status, act.status);
                compare_field("slot", exp.slot, act.slot);
                compare_field("writeback_needed", exp.writeback_needed,
                              act.writeback_needed);
                compare_field("flushed_count", exp.flushed_count, act.flushed_count);
                compare_field("hit_total", exp.hit_total, act.hit_total);
                compare_field("miss_total", exp.miss_total, act.miss_total);
                compare_field("writeback_total", exp.writeback_total,
                              act.writeback_total);
                compare_field("evict_total", exp.evict_total, act.evict_total);
            end
        endfunction
    endclass

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                start       = 1'b0;
    logic [OPCODE_W-1:0] opcode      = '0;
    logic [INODE_W-1:0]  inode       = '0;
    logic [OFFSET_W-1:0] page_offset = '0;
    logic [BYTES_W-1:0]  page_bytes  = '0;
    logic                mark_dirty  = 1'b0;
    logic                count_miss  = 1'b0;
    logic                busy;
    logic                done;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic                writeback_needed;
    logic [FLUSH_W-1:0]  flushed_count;
    logic [TOTAL_W-1:0]  hit_total;
    logic [TOTAL_W-1:0]  miss_total;
    logic [TOTAL_W-1:0]  writeback_total;
    logic [TOTAL_W-1:0]  evict_total;

    tag_store_mirror     mirror;
    int unsigned         quiet_cycles = 0;
    logic [INODE_W-1:0]  pool_inode  [INODE_POOL];
    logic [OFFSET_W-1:0] pool_offset [OFFSET_POOL];

    lru_page_cache_tag_store_top i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .opcode           (opcode),
        .inode            (inode),
        .page_offset      (page_offset),
        .page_bytes       (page_bytes),
        .mark_dirty       (mark_dirty),
        .count_miss       (count_miss),
        .done             (done),
        .status           (status),
        .slot             (slot),
        .writeback_needed (writeback_needed),
        .flushed_count    (flushed_count),
        .hit_total        (hit_total),
        .miss_total       (miss_total),
        .writeback_total  (writeback_total),
        .evict_total      (evict_total)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin : port_monitor
        command_t seen_cmd;
        outcome_t seen_res;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                seen_cmd.opcode      = opcode;
                seen_cmd.inode       = inode;
                seen_cmd.page_offset = page_offset;
                seen_cmd.page_bytes  = page_bytes;
                seen_cmd.mark_dirty  = mark_dirty;
                seen_cmd.count_miss  = count_miss;
                mirror.note_command(seen_cmd);
            end
            if (done)
            begin
                seen_res.status           = status;
                seen_res.slot             = slot;
                seen_res.writeback_needed = writeback_needed;
                seen_res.flushed_count    = flushed_count;
                seen_res.hit_total        = hit_total;
                seen_res.miss_total       = miss_total;
                seen_res.writeback_total  = writeback_total;
                seen_res.evict_total      = evict_total;
                mirror.check_result(seen_res);
            end
            if ((start && !busy) || done)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_command(input command_t c);
        start       <= 1'b1;
        opcode      <= c.opcode;
        inode       <= c.inode;
        page_offset <= c.page_offset;
        page_bytes  <= c.page_bytes;
        mark_dirty  <= c.mark_dirty;
        count_miss  <= c.count_miss;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic send_fields(input logic [OPCODE_W-1:0] op,
                               input logic [INODE_W-1:0] ino,
                               input logic [OFFSET_W-1:0] off,
                               input logic [BYTES_W-1:0] nbytes,
                               input logic dirty, input logic cmiss);
        command_t c;
        c.opcode      = op;
        c.inode       = ino;
        c.page_offset = off;
        c.page_bytes  = nbytes;
        c.mark_dirty  = dirty;
        c.count_miss  = cmiss;
        send_command(c);
    endtask

    // Each cycle the sender stays idle with the given chance in a hundred.
    task automatic maybe_pause(input int unsigned pct);
        while ($urandom_range(99) < pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (mirror.expected_results.size() != 0)
            @(posedge clk);
    endtask

    // Most items reuse a small set of tags so that hits, in-place updates and
    // evictions happen often; the rest is malformed or unrelated traffic.
    function automatic command_t random_command();
        command_t    c;
        int unsigned pick;
        c.opcode      = OP_LOOKUP;
        c.inode       = pool_inode[$urandom_range(INODE_POOL - 1)];
        c.page_offset = pool_offset[$urandom_range(OFFSET_POOL - 1)];
        c.page_bytes  = BYTES_W'($urandom_range(PAGE_LIMIT));
        c.mark_dirty  = 1'($urandom_range(1));
        c.count_miss  = 1'($urandom_range(1));
        pick = $urandom_range(99);
        if (pick < 40)
            c.opcode = OP_LOOKUP;
        else if (pick < 75)
            c.opcode = OP_INSERT;
        else if (pick < 85)
            c.opcode = OP_INVALIDATE;
        else if (pick < 88)
            c.opcode = OP_FLUSH;
        else if (pick < 89)
            c.opcode = OP_CLEAR;
        else if (pick < 91)
            c.opcode = OPCODE_W'($urandom_range(OPCODE_MAX, int'(OP_CLEAR) + 1));
        else
        begin
            c.opcode = OPCODE_W'($urandom_range(int'(OP_INVALIDATE)));
            case ($urandom_range(2))
                0: c.inode = '0;
                1:
                begin
                    c.inode       = $urandom;
                    c.page_offset = {$urandom, $urandom};
                end
                default:
                begin
                    c.opcode     = OP_INSERT;
                    c.page_bytes = BYTES_W'($urandom_range(BYTES_MAX, PAGE_LIMIT + 1));
                end
            endcase
        end
        return c;
    endfunction

    initial
    begin : stimulus
        int unsigned gap_pct [3];
        mirror = new();
        gap_pct = '{14, 48, 0};
        for (int i = 0; i < INODE_POOL; i++)
        begin
            pool_inode[i] = $urandom;
            if (pool_inode[i] == '0)
                pool_inode[i] = INODE_W'(i + 1);
        end
        for (int i = 0; i < OFFSET_POOL; i++)
            pool_offset[i] = {$urandom, $urandom};

        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: rejections, miss counting, fill, hit, update in place,
        // invalidation, reuse of a freed line, flush, bad opcodes and clear.
        send_fields(OP_LOOKUP, 32'd1, '0, '0, 1'b0, 1'b0);
        send_fields(OP_LOOKUP, 32'd1, '0, '0, 1'b0, 1'b1);
        send_fields(OP_LOOKUP, '0, '1, '0, 1'b0, 1'b1);
        send_fields(OP_INSERT, '0, '1, BYTES_W'(16), 1'b1, 1'b0);
        send_fields(OP_INSERT, 32'd7, 64'd7, BYTES_W'(PAGE_LIMIT + 1), 1'b0, 1'b0);
        send_fields(OP_INSERT, 32'd7, 64'd7, '1, 1'b1, 1'b0);
        send_fields(OP_INSERT, '1, '1, BYTES_W'(PAGE_LIMIT), 1'b1, 1'b0);
        send_fields(OP_INSERT, 32'd1, '0, '0, 1'b0, 1'b0);
        send_fields(OP_LOOKUP, '1, '1, '0, 1'b0, 1'b0);
        send_fields(OP_INSERT, '1, '1, BYTES_W'(16), 1'b0, 1'b0);
        send_fields(OP_INSERT, 32'd1, '0, '0, 1'b1, 1'b0);
        send_fields(OP_INVALIDATE, '0, '0, '0, 1'b0, 1'b0);
        send_fields(OP_INVALIDATE, 32'd2, '0, '0, 1'b0, 1'b0);
        send_fields(OP_INVALIDATE, '1, '1, '0, 1'b0, 1'b0);
        send_fields(OP_LOOKUP, '1, '1, '0, 1'b0, 1'b1);
        send_fields(OP_INSERT, 32'd5, 64'd5, BYTES_W'(512), 1'b1, 1'b0);
        send_fields(OP_FLUSH, $urandom, {$urandom, $urandom}, '0, 1'b1, 1'b1);
        send_fields(OP_FLUSH, '0, '0, '1, 1'b0, 1'b0);
        for (int op = int'(OP_CLEAR) + 1; op <= OPCODE_MAX; op++)
            send_fields(OPCODE_W'(op), 32'd5, 64'd5, '0, 1'b0, 1'b1);
        send_fields(OP_CLEAR, '1, '1, '1, 1'b1, 1'b1);
        send_fields(OP_LOOKUP, 32'd5, 64'd5, '0, 1'b0, 1'b1);
        drain_results();

        for (int phase = 0; phase < 3; phase++)
        begin
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                send_command(random_command());
                maybe_pause(gap_pct[phase]);
            end
            // Hold the next item back until the store has answered everything.
            drain_results();
        end

        repeat (TAIL_CYCLES)
            @(posedge clk);
        if (mirror.mismatches == 0 && mirror.expected_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin : watchdog
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
